// ----- sv/pprle_pkg.sv -----
package pprle_pkg;

  localparam int unsigned ByteBits = 8;
  localparam int unsigned BppW     = 4;
  localparam int unsigned RunCntW  = 6;
  localparam int unsigned MaxRes   = 4;
  localparam int unsigned QDepth   = 8;
  localparam int unsigned QCntW    = $clog2(QDepth + 1);
  localparam int unsigned ResIdxW  = $clog2(MaxRes);
  localparam int unsigned ResCntW  = $clog2(MaxRes + 1);

  localparam logic [ByteBits-1:0] RunMark = 8'hC0;
  localparam logic [RunCntW-1:0]  RunMax  = 6'd63;
  localparam logic [BppW-1:0]     BppRst  = 4'd8;

  // one encoded byte with its framing marks
  typedef struct packed {
    logic [ByteBits-1:0] data;
    logic                last_item;
    logic                last_line;
  } res_beat_t;

endpackage

// ----- sv/pixel_pack_rle_encoder_core.sv -----
// The bytes caused by a pixel beat are in the output queue in the cycle after acceptance;
// the first appears on out_* in that cycle if nothing older waits, the rest follow one per cycle as out_ready allows.
// Throughput: one pixel beat per cycle while at most four bytes wait in the eight-entry queue;
// output drains one byte per cycle while out_ready is high, so a burst of up to four bytes stalls input briefly.
// Reset (rst_n low, synchronous): queue empty, packer and run state cleared, bits_per_pixel = 8.
module pixel_pack_rle_encoder_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [pprle_pkg::BppW-1:0]    cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [pprle_pkg::ByteBits-1:0] in_pixel_index,
  input  logic                          in_end_of_line,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [pprle_pkg::ByteBits-1:0] out_byte,
  output logic                          out_last_of_item,
  output logic                          out_last_of_line
);
  import pprle_pkg::*;

  // state
  logic [BppW-1:0]     bpp_r;
  logic [ByteBits-1:0] accum_r, accum_nxt;
  logic [3:0]          shift_r, shift_nxt;
  logic [ByteBits-1:0] run_val_r, run_val_nxt;
  logic [RunCntW-1:0]  run_cnt_r, run_cnt_nxt;
  logic                run_open_r, run_open_nxt;
  res_beat_t           q_r [QDepth];
  res_beat_t           q_nxt [QDepth];
  logic [QCntW-1:0]    cnt_r, cnt_nxt;

  logic in_acc, pop;

  // step datapath
  logic [3:0]          b_eff;
  logic [ByteBits-1:0] mask, pix, accum_new;
  logic [4:0]          sum, sum2;
  logic                fit, full, push, extend;
  logic [3:0]          placed2;
  logic [ByteBits-1:0] mid_val;
  logic [RunCntW-1:0]  mid_cnt;
  logic                mid_open;
  res_beat_t           res [MaxRes];
  logic [ResCntW-1:0]  nres;
  logic [QCntW-1:0]    base;

  assign in_ready = (cnt_r <= QCntW'(QDepth - MaxRes));
  assign in_acc   = in_valid && in_ready;
  assign out_valid = (cnt_r != '0);
  assign pop      = out_valid && out_ready;
  assign out_byte         = q_r[0].data;
  assign out_last_of_item = q_r[0].last_item;
  assign out_last_of_line = q_r[0].last_line;

  // clamp width, mask pixel and place it below the bits already placed
  always_comb begin
    if (bpp_r == '0) begin
      b_eff = 4'd1;
    end else if (bpp_r > 4'(ByteBits)) begin
      b_eff = 4'(ByteBits);
    end else begin
      b_eff = bpp_r;
    end
    mask = 8'hFF >> (4'(ByteBits) - b_eff);
    pix  = in_pixel_index & mask;
    sum  = {1'b0, shift_r} + {1'b0, b_eff};
    fit  = (sum <= 5'(ByteBits));
    if (fit) begin
      accum_new = accum_r | (pix << 4'(5'(ByteBits) - sum));
      placed2   = sum[3:0];
    end else begin
      accum_new = accum_r | (pix >> 4'(sum - 5'(ByteBits)));
      placed2   = 4'(ByteBits);
    end
    sum2 = {1'b0, placed2} + {1'b0, b_eff};
    full = (sum2 > 5'(ByteBits));
    push = full || (in_end_of_line && placed2 != '0);
  end

  // run encoder: close the old run on a new byte, then flush at end of line
  always_comb begin
    for (int k = 0; k < MaxRes; k++) begin
      res[k] = '0;
    end
    nres     = '0;
    extend   = run_open_r && (accum_new == run_val_r) && (run_cnt_r < RunMax);
    mid_val  = run_val_r;
    mid_cnt  = run_cnt_r;
    mid_open = run_open_r;
    if (push) begin
      if (extend) begin
        mid_cnt = run_cnt_r + 1'b1;
      end else begin
        if (run_open_r) begin
          if (run_cnt_r > 6'd1 || (run_val_r & RunMark) == RunMark) begin
            res[ResIdxW'(nres)].data = RunMark | {2'b00, run_cnt_r};
            nres = nres + 1'b1;
          end
          res[ResIdxW'(nres)].data = run_val_r;
          nres = nres + 1'b1;
        end
        mid_val  = accum_new;
        mid_cnt  = 6'd1;
        mid_open = 1'b1;
      end
    end
    if (in_end_of_line && mid_open) begin
      if (mid_cnt > 6'd1 || (mid_val & RunMark) == RunMark) begin
        res[ResIdxW'(nres)].data = RunMark | {2'b00, mid_cnt};
        nres = nres + 1'b1;
      end
      res[ResIdxW'(nres)].data = mid_val;
      nres = nres + 1'b1;
    end
    if (nres != '0) begin
      res[ResIdxW'(nres - 1'b1)].last_item = 1'b1;
      res[ResIdxW'(nres - 1'b1)].last_line = in_end_of_line;
    end
  end

  // next packer and run state
  always_comb begin
    accum_nxt    = accum_r;
    shift_nxt    = shift_r;
    run_val_nxt  = run_val_r;
    run_cnt_nxt  = run_cnt_r;
    run_open_nxt = run_open_r;
    if (in_acc) begin
      if (in_end_of_line) begin
        accum_nxt    = '0;
        shift_nxt    = '0;
        run_val_nxt  = '0;
        run_cnt_nxt  = '0;
        run_open_nxt = 1'b0;
      end else begin
        accum_nxt    = full ? '0 : accum_new;
        shift_nxt    = full ? '0 : placed2;
        run_val_nxt  = mid_val;
        run_cnt_nxt  = mid_cnt;
        run_open_nxt = mid_open;
      end
    end
  end

  // output queue: advance on pop, append the new beats behind what remains
  always_comb begin
    base = cnt_r - QCntW'(pop);
    for (int i = 0; i < QDepth - 1; i++) begin
      q_nxt[i] = pop ? q_r[i+1] : q_r[i];
    end
    q_nxt[QDepth-1] = q_r[QDepth-1];
    if (in_acc) begin
      for (int i = 0; i < QDepth; i++) begin
        if (QCntW'(i) >= base && QCntW'(i) < base + QCntW'(nres)) begin
          q_nxt[i] = res[ResIdxW'(QCntW'(i) - base)];
        end
      end
    end
    cnt_nxt = base + (in_acc ? QCntW'(nres) : '0);
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpp_r      <= BppRst;
      accum_r    <= '0;
      shift_r    <= '0;
      run_val_r  <= '0;
      run_cnt_r  <= '0;
      run_open_r <= 1'b0;
      cnt_r      <= '0;
    end else begin
      if (cfg_wr_en) begin
        bpp_r <= cfg_wr_data;
      end
      accum_r    <= accum_nxt;
      shift_r    <= shift_nxt;
      run_val_r  <= run_val_nxt;
      run_cnt_r  <= run_cnt_nxt;
      run_open_r <= run_open_nxt;
      cnt_r      <= cnt_nxt;
    end
  end

  // queue payload
  always_ff @(posedge clk) begin
    for (int i = 0; i < QDepth; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCntW'(QDepth))
    else $error("output queue count beyond depth");

  a_shift_bound: assert property (@(posedge clk) disable iff (!rst_n)
    shift_r < 4'(ByteBits))
    else $error("packer holds a full byte");

  a_eol_clear: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_end_of_line |=> shift_r == '0 && !run_open_r)
    else $error("state not cleared after end of line");

  a_run_len: assert property (@(posedge clk) disable iff (!rst_n)
    run_open_r |-> run_cnt_r != '0)
    else $error("open run with zero length");
`endif

endmodule

// ----- tb/tb.sv -----
module tb;
  import pprle_pkg::*;

  localparam int unsigned RandomItems = 280;

  logic                clk              = 1'b0;
  logic                rst_n            = 1'b0;
  logic                cfg_wr_en        = 1'b0;
  logic [BppW-1:0]     cfg_wr_data      = '0;
  logic                in_valid         = 1'b0;
  logic                in_ready;
  logic [ByteBits-1:0] in_pixel_index   = '0;
  logic                in_end_of_line   = 1'b0;
  logic                out_valid;
  logic                out_ready        = 1'b0;
  logic [ByteBits-1:0] out_byte;
  logic                out_last_of_item;
  logic                out_last_of_line;

  // encoder state as the block should hold it
  logic [BppW-1:0]     width_reg  = BppRst;
  logic [ByteBits-1:0] pack_byte  = '0;
  int unsigned         pack_fill  = 0;
  logic [ByteBits-1:0] run_byte   = '0;
  logic [RunCntW-1:0]  run_len    = '0;
  logic                run_live   = 1'b0;
  res_beat_t           step_beats[$];
  res_beat_t           encoded_bytes_due[$];

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned pixels_sent    = 0;
  int unsigned lines_sent     = 0;
  int unsigned bytes_checked  = 0;
  int unsigned mismatches     = 0;
  int unsigned width_step     = 0;
  int unsigned width_order[16] = '{8, 1, 2, 4, 0, 15, 3, 5, 6, 7, 9, 10, 11, 12, 13, 14};

  pixel_pack_rle_encoder_core u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_pixel_index   (in_pixel_index),
    .in_end_of_line   (in_end_of_line),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_byte         (out_byte),
    .out_last_of_item (out_last_of_item),
    .out_last_of_line (out_last_of_line)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Effective pixel width: 0 acts as 1, anything above 8 acts as 8
  function automatic int unsigned pixel_width();
    if (width_reg == 0) return 1;
    if (width_reg > ByteBits) return ByteBits;
    return 32'(width_reg);
  endfunction

  function automatic logic [ByteBits-1:0] width_mask();
    logic [ByteBits-1:0] m;
    m = ByteBits'((1 << pixel_width()) - 1);
    return m;
  endfunction

  function automatic void emit_byte(logic [ByteBits-1:0] b);
    res_beat_t beat;
    beat.data      = b;
    beat.last_item = 1'b0;
    beat.last_line = 1'b0;
    step_beats.push_back(beat);
  endfunction

  // Emit the open run; escape a lone byte whose top two bits are set
  function automatic void close_run();
    if (run_live) begin
      if (run_len > 1 || (run_byte & RunMark) == RunMark)
        emit_byte(RunMark | {2'b00, run_len});
      emit_byte(run_byte);
    end
  endfunction

  // Extend the open run, or close it and start a new one
  function automatic void run_add(logic [ByteBits-1:0] b);
    if (run_live && b == run_byte && run_len < RunMax) begin
      run_len++;
    end else begin
      close_run();
      run_byte = b;
      run_len  = RunCntW'(1);
      run_live = 1'b1;
    end
  endfunction

  // Pack one pixel, feed completed bytes to the run coder, flush at end of line
  function automatic void predict_pixel(logic [ByteBits-1:0] pix, logic eol);
    int unsigned         w;
    int unsigned         fill;
    logic [ByteBits-1:0] masked;
    res_beat_t           tail;
    w      = pixel_width();
    masked = pix & width_mask();
    fill   = pack_fill;
    step_beats.delete();
    if (fill + w <= ByteBits) begin
      pack_byte = pack_byte | (masked << (ByteBits - fill - w));
      fill      = fill + w;
    end else begin
      // pixel wider than the room left: keep its top bits only
      pack_byte = pack_byte | (masked >> (fill + w - ByteBits));
      fill      = ByteBits;
    end
    if (fill + w > ByteBits) begin
      run_add(pack_byte);
      pack_byte = '0;
      fill      = 0;
    end
    pack_fill = fill;
    if (eol) begin
      if (pack_fill != 0) run_add(pack_byte);
      close_run();
      pack_byte = '0;
      pack_fill = 0;
      run_byte  = '0;
      run_len   = '0;
      run_live  = 1'b0;
      if (step_beats.size() > 0) begin
        tail = step_beats.pop_back();
        tail.last_line = 1'b1;
        step_beats.push_back(tail);
      end
    end
    if (step_beats.size() > 0) begin
      tail = step_beats.pop_back();
      tail.last_item = 1'b1;
      step_beats.push_back(tail);
    end
    foreach (step_beats[i]) encoded_bytes_due.push_back(step_beats[i]);
  endfunction

  // Drive one pixel beat after a random gap and hold it until accepted
  task automatic send_pixel(input logic [ByteBits-1:0] pix, input logic eol);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid       <= 1'b1;
    in_pixel_index <= pix;
    in_end_of_line <= eol;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_pixel(pix, eol);
    pixels_sent++;
    if (eol) lines_sent++;
  endtask

  // Drop valid, wait for every due byte, then let the pipeline go quiet
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (encoded_bytes_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_width(input logic [BppW-1:0] w);
    settle();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= w;
    @(posedge clk);
    width_reg = w;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Stall the result channel at random
  always @(negedge clk) begin
    out_ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
  end

  // Compare each accepted result beat with the oldest due byte
  always @(posedge clk) begin : check_beats
    res_beat_t want;
    if (rst_n && out_valid && out_ready) begin
      if (encoded_bytes_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected beat byte=%02h last_item=%0b last_line=%0b",
                   out_byte, out_last_of_item, out_last_of_line);
      end else begin
        want = encoded_bytes_due.pop_front();
        bytes_checked++;
        if (out_byte !== want.data || out_last_of_item !== want.last_item ||
            out_last_of_line !== want.last_line) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: beat %0d expected %02h/%0b/%0b got %02h/%0b/%0b",
                     bytes_checked, want.data, want.last_item, want.last_line,
                     out_byte, out_last_of_item, out_last_of_line);
        end
      end
    end
  end

  // Reset width of 8: runs, escaped and bare single bytes, extremes
  task automatic test_default_width();
    send_pixel(8'h00, 1'b0);
    send_pixel(8'h00, 1'b0);
    send_pixel(8'h00, 1'b1);
    send_pixel(8'hFF, 1'b1);
    send_pixel(8'hBF, 1'b1);
    send_pixel(8'hC0, 1'b0);
    send_pixel(8'h3F, 1'b1);
    send_pixel(8'h55, 1'b0);
    send_pixel(8'hAA, 1'b0);
    send_pixel(8'hAA, 1'b1);
  endtask

  // Narrow and out-of-range widths, width changes inside a partial byte
  task automatic test_width_changes();
    write_width(4'd4);
    send_pixel(8'hFA, 1'b0);
    write_width(4'd3);
    send_pixel(8'hFF, 1'b0);
    write_width(4'd2);
    send_pixel(8'h01, 1'b0);
    write_width(4'd8);
    send_pixel(8'hFF, 1'b1);
    write_width(4'd0);
    send_pixel(8'hFF, 1'b0);
    send_pixel(8'h00, 1'b0);
    send_pixel(8'h01, 1'b1);
    write_width(4'd15);
    send_pixel(8'hE1, 1'b0);
    send_pixel(8'hE1, 1'b1);
    write_width(4'd1);
    send_pixel(8'h00, 1'b1);
  endtask

  // Long run of one byte: closes at 63 and reopens
  task automatic test_run_limit();
    write_width(4'd8);
    for (int i = 0; i < 130; i++) send_pixel(8'hE7, i == 129);
  endtask

  // Scanlines built from runs of equal masked pixels with random upper bits
  task automatic test_random_lines(input int unsigned idle_pct, input int unsigned stall_pct,
                                   input int unsigned item_goal);
    int unsigned         done;
    int unsigned         line_no;
    int unsigned         len;
    int unsigned         seg_left;
    logic [ByteBits-1:0] base;
    logic [ByteBits-1:0] m;
    logic [ByteBits-1:0] pix;
    done    = 0;
    line_no = 0;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    while (done < item_goal) begin
      if (line_no % 2 == 0) begin
        write_width(BppW'(width_order[width_step % 16]));
        width_step++;
      end
      line_no++;
      len      = ($urandom_range(99) < 5) ? $urandom_range(70, 64) : $urandom_range(24, 1);
      seg_left = (len > 60) ? len : 0;
      base     = ByteBits'($urandom_range(255));
      for (int i = 0; i < len; i++) begin
        if (seg_left == 0) begin
          base     = ByteBits'($urandom_range(255));
          seg_left = $urandom_range(12, 1);
        end
        seg_left--;
        // occasionally change width in the middle of a line
        if (i != len - 1 && $urandom_range(63) == 0) write_width(BppW'($urandom_range(15)));
        m = width_mask();
        if ($urandom_range(7) == 0) pix = ByteBits'($urandom_range(255));
        else pix = (base & m) | (ByteBits'($urandom_range(255)) & ~m);
        send_pixel(pix, i == len - 1);
        done++;
      end
    end
    settle();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_default_width();
    test_width_changes();
    test_run_limit();
    test_random_lines(0, 0, RandomItems / 4);
    test_random_lines(74, 0, RandomItems / 4);
    test_random_lines(0, 74, RandomItems / 4);
    test_random_lines(17, 17, RandomItems / 4);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    settle();
    repeat (10) @(posedge clk);
    $display("Sent %0d pixels in %0d scanlines at normal, narrow and out-of-range widths",
             pixels_sent, lines_sent);
    $display("Checked %0d encoded bytes under four flow-control phases, %0d mismatches",
             bytes_checked, mismatches);
    if (mismatches == 0) begin
      $display("pixel_pack_rle_encoder_core test passed");
    end else begin
      $display("pixel_pack_rle_encoder_core test failed");
    end
    $finish;
  end

  // Bound the run in case the block hangs
  initial begin
    #5000000;
    $display("Timeout with %0d bytes still due", encoded_bytes_due.size());
    $display("pixel_pack_rle_encoder_core test failed");
    $finish;
  end

endmodule
